FILE: design/touch_hold_detector_core_macros.svh
// ----------------------------------------------------------------------------
// touch_hold_detector_core_macros: assertion macros
// Clocked on aclk, disabled while aresetn is low. Empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TOUCH_HOLD_DETECTOR_CORE_MACROS_SVH
`define TOUCH_HOLD_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define THD_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("thd assertion failed");

// next-cycle implication
`define THD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("thd assertion failed");

`else

`define THD_ASSERT_NOW(name, ante, cons)
`define THD_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: design/thd_pkg.sv
// ----------------------------------------------------------------------------
// thd_pkg: shared types and constants
// Channel state, configuration and result records for the touch detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package thd_pkg;

    localparam int CHANNELS   = 16;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CHAN_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 8;
    localparam int S_TDATA_W  = 40;   // 36 bits of fields, padded to bytes
    localparam int M_TDATA_W  = 56;   // 55 bits of fields, padded to bytes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SAMPLE_W-1:0] BASE_MAX = 16'd60000;
    localparam logic [CNT_W-1:0]    CNT_MAX  = 8'hFF;

    // reciprocal multipliers: floor(x/5) and floor(y/25), exact over the used ranges
    localparam logic [18:0] DIV5_MULT   = 19'd419431;
    localparam int          DIV5_SHIFT  = 21;
    localparam logic [21:0] DIV25_MULT  = 22'd2684355;
    localparam int          DIV25_SHIFT = 26;

    // contact phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_ACTIVE  = 3'b010,
        PH_RELCONF = 3'b100
    } phase_t;

    // phase as reported on the result word
    localparam logic [1:0] PHASE_CODE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_CODE_ACTIVE  = 2'd1;
    localparam logic [1:0] PHASE_CODE_RELCONF = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_CONFIRM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CONFIRM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_FRAMES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_MARGIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_LIMIT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LEVEL       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CAP        = 3'd7;

    typedef struct packed {
        logic [CNT_W-1:0]    enter_confirm;
        logic [CNT_W-1:0]    release_confirm;
        logic [CNT_W-1:0]    rearm_frames;
        logic [CNT_W-1:0]    cooldown_frames;
        logic [SAMPLE_W-1:0] rise_margin;
        logic [SAMPLE_W-1:0] rise_limit;
        logic [SAMPLE_W-1:0] sat_level;
        logic [SAMPLE_W-1:0] hold_cap;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enter_confirm:   8'd2,
        release_confirm: 8'd2,
        rearm_frames:    8'd2,
        cooldown_frames: 8'd16,
        rise_margin:     16'd128,
        rise_limit:      16'd1000,
        sat_level:       16'hFF00,
        hold_cap:        16'd10000
    };

    typedef struct packed {
        logic [SAMPLE_W-1:0] base;      // 0 = not yet seeded
        logic [SAMPLE_W-1:0] ref_lvl;   // frozen reference during contact
        phase_t              ph;
        logic [CNT_W-1:0]    enter_cnt;
        logic [CNT_W-1:0]    release_cnt;
        logic [CNT_W-1:0]    rearm_cnt;
        logic [CNT_W-1:0]    cooldown_cnt;
        logic [SAMPLE_W-1:0] hold_ticks;
        logic [SAMPLE_W-1:0] follow;
    } chan_state_t;

    localparam chan_state_t CHAN_STATE_RESET = '{
        base:         16'd0,
        ref_lvl:      16'd0,
        ph:           PH_IDLE,
        enter_cnt:    8'd0,
        release_cnt:  8'd0,
        rearm_cnt:    8'd0,
        cooldown_cnt: 8'd0,
        hold_ticks:   16'd0,
        follow:       16'd0
    };

    // first member is the top of the vector: out_chan lands in the low bits
    typedef struct packed {
        logic [SAMPLE_W-1:0] baseline_now;
        logic [SAMPLE_W-1:0] release_level;
        logic [SAMPLE_W-1:0] hold_count;
        logic [1:0]          phase;
        logic                touched;
        logic [CHAN_W-1:0]   out_chan;
    } result_t;

endpackage

`default_nettype wire

FILE: design/thd_update.sv
// ----------------------------------------------------------------------------
// thd_update: per-channel next-state and result logic
// Baseline tracking, envelope follow and contact phase for one word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module thd_update
    import thd_pkg::*;
(
    input  cfg_t                cfg,
    input  chan_state_t         st,
    input  logic                chan_ok,
    input  logic [CHAN_W-1:0]   chan,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] thr,
    output chan_state_t         st_next,
    output result_t             res
);

    function automatic logic [SAMPLE_W-1:0] max16(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // max(delta*7/8, static release level)
    function automatic logic [SAMPLE_W-1:0] env_target(input logic [SAMPLE_W-1:0] srel,
                                                      input logic [SAMPLE_W-1:0] delta);
        logic [18:0] d7;
        d7 = {delta, 3'b000} - {3'b000, delta};
        return max16(d7[18:3], srel);
    endfunction

    // rise half the gap, fall an eighth of it (rounded up)
    function automatic logic [SAMPLE_W-1:0] env_step(input logic [SAMPLE_W-1:0] f,
                                                    input logic [SAMPLE_W-1:0] t);
        logic [16:0] up;
        logic [16:0] dn;
        up = ({1'b0, t} - {1'b0, f} + 17'd1) >> 1;
        dn = ({1'b0, f} - {1'b0, t} + 17'd7) >> 3;
        if (t > f) begin
            return f + up[15:0];
        end else if (t < f) begin
            return f - dn[15:0];
        end
        return t;
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_base(input logic [SAMPLE_W-1:0] v);
        return (v > BASE_MAX) ? BASE_MAX : v;
    endfunction

    logic [SAMPLE_W-1:0] b;
    logic [SAMPLE_W-1:0] srel;
    logic [SAMPLE_W-1:0] fl_idle;
    logic [18:0]         sum5;
    logic [37:0]         prod5;
    logic [21:0]         sum50;
    logic [42:0]         prod50;
    logic [SAMPLE_W-1:0] q5;
    logic [SAMPLE_W-1:0] q50;
    logic                rise_block;
    logic [SAMPLE_W-1:0] ib_base;
    logic [CNT_W-1:0]    ib_cd;
    logic                entry_hit;
    logic [CNT_W-1:0]    ec_inc;
    logic [CNT_W-1:0]    rc_inc;
    logic [SAMPLE_W-1:0] enter_delta;
    logic [SAMPLE_W-1:0] enter_ft;
    logic [SAMPLE_W-1:0] delta_a;
    logic [SAMPLE_W-1:0] fl_act;
    logic [SAMPLE_W-1:0] rel_act;
    logic [SAMPLE_W-1:0] ht_inc;
    logic [SAMPLE_W-1:0] rel;
    logic [1:0]          ph_code;

    // seed and shared terms
    always_comb begin
        b       = (st.base == '0) ? sample : st.base;
        srel    = (thr[15:1] == '0) ? 16'd1 : {1'b0, thr[15:1]};
        fl_idle = (st.follow != '0) ? env_step(st.follow, srel) : st.follow;

        // (4b + raw) / 5 and (49b + raw) / 50 by reciprocal
        sum5   = {1'b0, b, 2'b00} + {3'b000, sample};
        prod5  = 38'(sum5) * 38'(DIV5_MULT);
        q5     = prod5[DIV5_SHIFT +: SAMPLE_W];
        sum50  = {1'b0, b, 5'b00000} + {2'b00, b, 4'b0000} + {6'd0, b} + {6'd0, sample};
        prod50 = 43'(sum50[21:1]) * 43'(DIV25_MULT);
        q50    = prod50[DIV25_SHIFT +: SAMPLE_W];

        rise_block = (({1'b0, b} + {1'b0, cfg.rise_limit}) <= {1'b0, sample})
                  || (({1'b0, b} + {1'b0, cfg.rise_margin}) < {1'b0, sample});

        if (sample <= b) begin
            ib_base = clamp_base(q5);
            ib_cd   = st.cooldown_cnt;
        end else if (st.cooldown_cnt != '0) begin
            ib_base = b;
            ib_cd   = st.cooldown_cnt - 8'd1;
        end else if (rise_block) begin
            ib_base = b;
            ib_cd   = st.cooldown_cnt;
        end else begin
            ib_base = clamp_base(q50);
            ib_cd   = st.cooldown_cnt;
        end

        entry_hit = ({1'b0, sample} > ({1'b0, b} + {1'b0, thr}))
                 || (sample >= cfg.sat_level);
        ec_inc = (st.enter_cnt == CNT_MAX) ? st.enter_cnt : st.enter_cnt + 8'd1;
        rc_inc = (st.release_cnt == CNT_MAX) ? st.release_cnt : st.release_cnt + 8'd1;

        enter_delta = (sample > b) ? sample - b : '0;
        enter_ft    = env_target(srel, enter_delta);

        delta_a = (sample > st.ref_lvl) ? sample - st.ref_lvl : '0;
        fl_act  = env_step(st.follow, env_target(srel, delta_a));
        rel_act = max16(fl_act, srel);

        ht_inc = (st.hold_ticks < cfg.hold_cap) ? st.hold_ticks + 16'd1 : st.hold_ticks;
    end

    // phase machine
    always_comb begin
        st_next      = st;
        st_next.base = b;
        rel          = srel;

        if (st.ph == PH_IDLE) begin
            st_next.ref_lvl = b;
            st_next.follow  = fl_idle;
            if (st.rearm_cnt != '0) begin
                st_next.rearm_cnt    = st.rearm_cnt - 8'd1;
                st_next.enter_cnt    = '0;
                st_next.hold_ticks   = '0;
                st_next.release_cnt  = '0;
                rel                  = max16(fl_idle, srel);
                st_next.base         = ib_base;
                st_next.cooldown_cnt = ib_cd;
                st_next.ref_lvl      = ib_base;
            end else if (entry_hit) begin
                if (ec_inc >= cfg.enter_confirm) begin
                    st_next.hold_ticks   = 16'd1;
                    st_next.enter_cnt    = '0;
                    st_next.release_cnt  = '0;
                    st_next.rearm_cnt    = '0;
                    st_next.ph           = PH_ACTIVE;
                    st_next.follow       = enter_ft;
                    st_next.cooldown_cnt = cfg.cooldown_frames;
                    rel                  = enter_ft;
                end else begin
                    st_next.enter_cnt   = ec_inc;
                    st_next.hold_ticks  = '0;
                    st_next.release_cnt = '0;
                    st_next.rearm_cnt   = '0;
                end
            end else begin
                st_next.enter_cnt    = '0;
                st_next.hold_ticks   = '0;
                st_next.release_cnt  = '0;
                st_next.rearm_cnt    = '0;
                rel                  = max16(fl_idle, srel);
                st_next.base         = ib_base;
                st_next.cooldown_cnt = ib_cd;
                st_next.ref_lvl      = ib_base;
            end
        end else begin
            st_next.follow = fl_act;
            rel            = rel_act;
            if ((delta_a < rel_act) && (sample < cfg.sat_level)) begin
                st_next.ph = PH_RELCONF;
                if (rc_inc >= cfg.release_confirm) begin
                    st_next.hold_ticks   = '0;
                    st_next.enter_cnt    = '0;
                    st_next.release_cnt  = '0;
                    st_next.rearm_cnt    = cfg.rearm_frames;
                    st_next.cooldown_cnt = cfg.cooldown_frames;
                    st_next.ph           = PH_IDLE;
                    st_next.ref_lvl      = b;
                end else begin
                    st_next.release_cnt = rc_inc;
                    st_next.hold_ticks  = ht_inc;
                end
            end else begin
                st_next.enter_cnt   = '0;
                st_next.release_cnt = '0;
                st_next.rearm_cnt   = '0;
                st_next.ph          = PH_ACTIVE;
                st_next.hold_ticks  = ht_inc;
            end
        end
    end

    always_comb begin
        case (st_next.ph)
            PH_IDLE:    ph_code = PHASE_CODE_IDLE;
            PH_ACTIVE:  ph_code = PHASE_CODE_ACTIVE;
            PH_RELCONF: ph_code = PHASE_CODE_RELCONF;
            default:    ph_code = PHASE_CODE_IDLE;
        endcase
    end

    // out-of-range channel: only the channel number comes back
    always_comb begin
        res          = '0;
        res.out_chan = chan;
        if (chan_ok) begin
            res.touched       = (st_next.ph != PH_IDLE);
            res.phase         = ph_code;
            res.hold_count    = st_next.hold_ticks;
            res.release_level = rel;
            res.baseline_now  = st_next.base;
        end
    end

endmodule

`default_nettype wire

FILE: design/touch_hold_detector_core.sv
// ----------------------------------------------------------------------------
// touch_hold_detector_core: per-channel capacitive touch and hold detector
// Result word: registered in the output stage after passing through the input stage.
// Throughput: one word per cycle while the sink is ready, bound by the read-modify-write
// of the per-channel state registers. Reset: aresetn low (sync) clears state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "touch_hold_detector_core_macros.svh"

module touch_hold_detector_core
    import thd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // input words
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // chan[3:0], sample[19:4],
                                                  // thresh[35:20], pad

    // result words
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [M_TDATA_W-1:0]  m_tdata,   // out_chan[3:0], touched[4],
                                                  // phase[6:5], hold_count[22:7],
                                                  // release_level[38:23],
                                                  // baseline_now[54:39], pad

    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Two register stages:
    //   in_*_reg   : captured input word
    //   out_*_reg  : finished result word, held until the sink takes it
    // The channel state update happens as the word moves from the input
    // stage to the output stage, so a word for the same channel in the
    // very next cycle already sees the updated state.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    logic [CHAN_W-1:0]   in_chan_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic [SAMPLE_W-1:0] in_thr_reg;

    logic                out_valid_reg;
    result_t             out_data_reg;

    cfg_t                cfg_reg;
    chan_state_t         st_reg [CHANNELS];

    logic                adv;       // output stage can take a word this cycle
    logic                fire;      // input stage word moves on
    logic                chan_ok;
    logic [CH_IDX_W-1:0] idx;
    chan_state_t         st_next;
    result_t             res;

    assign adv      = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && adv;
    // input stage refills as it drains, so back-to-back words flow freely
    assign s_tready = !in_valid_reg || adv;

    assign chan_ok  = (32'(in_chan_reg) < CHANNELS);
    assign idx      = CH_IDX_W'(in_chan_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, out_data_reg};

    thd_update u_update (
        .cfg     (cfg_reg),
        .st      (st_reg[idx]),
        .chan_ok (chan_ok),
        .chan    (in_chan_reg),
        .sample  (in_sample_reg),
        .thr     (in_thr_reg),
        .st_next (st_next),
        .res     (res)
    );

    // ------------------------------------------------------------------
    // Control, configuration and channel state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= CFG_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                st_reg[i] <= CHAN_STATE_RESET;
            end
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
            // out-of-range channels leave all state untouched
            if (fire && chan_ok) begin
                st_reg[idx] <= st_next;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ENTER_CONFIRM:   cfg_reg.enter_confirm   <= cfg_wdata[CNT_W-1:0];
                    CFG_RELEASE_CONFIRM: cfg_reg.release_confirm <= cfg_wdata[CNT_W-1:0];
                    CFG_REARM_FRAMES:    cfg_reg.rearm_frames    <= cfg_wdata[CNT_W-1:0];
                    CFG_COOLDOWN_FRAMES: cfg_reg.cooldown_frames <= cfg_wdata[CNT_W-1:0];
                    CFG_RISE_MARGIN:     cfg_reg.rise_margin     <= cfg_wdata;
                    CFG_RISE_LIMIT:      cfg_reg.rise_limit      <= cfg_wdata;
                    CFG_SAT_LEVEL:       cfg_reg.sat_level       <= cfg_wdata;
                    CFG_HOLD_CAP:        cfg_reg.hold_cap        <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_chan_reg   <= s_tdata[3:0];
            in_sample_reg <= s_tdata[19:4];
            in_thr_reg    <= s_tdata[35:20];
        end
        if (fire) begin
            out_data_reg <= res;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a full pipe with a stalled sink must stop taking words
    `THD_ASSERT_NOW(a_no_overrun, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    // a word that leaves the input stage shows up as a result
    `THD_ASSERT_NEXT(a_word_moves, in_valid_reg && adv, out_valid_reg)
    // touched flag and reported phase agree
    `THD_ASSERT_NOW(a_touched_phase, out_valid_reg, out_data_reg.touched == (out_data_reg.phase != PHASE_CODE_IDLE))
    // an idle channel carries no hold time
    `THD_ASSERT_NOW(a_idle_no_hold, out_valid_reg && (out_data_reg.phase == PHASE_CODE_IDLE), out_data_reg.hold_count == '0)

endmodule

`default_nettype wire
